/* src/trxp_pkg.sv */
// ----------------------------------------------------------------------------
// trxp_pkg
// shared types and constants of the telnet com-port receive parser
// ----------------------------------------------------------------------------
package trxp_pkg;

  // only the first ten command bytes are ever read back (longest echo)
  localparam int unsigned ECHO_DEPTH = 10;
  localparam int unsigned IDX_W      = $clog2(ECHO_DEPTH);

  // apb address width: one 32-bit register plus room to decode beyond it
  localparam int unsigned ADDR_W = 3;
  localparam logic        REG_IDLE_BAUD = 1'b0;
  localparam logic [31:0] IDLE_BAUD_RESET = 32'd115200;

  // telnet bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] OPT_ECHO    = 8'd1;
  localparam logic [7:0] OPT_COMPORT = 8'd44;

  // com-port option opcodes
  localparam logic [7:0] OP_SET_BAUD     = 8'd1;
  localparam logic [7:0] OP_SET_DATASIZE = 8'd2;
  localparam logic [7:0] OP_SET_PARITY   = 8'd3;
  localparam logic [7:0] OP_SET_STOPSIZE = 8'd4;
  localparam logic [7:0] OP_SET_CONTROL  = 8'd5;
  localparam logic [7:0] OP_PURGE_DATA   = 8'd12;
  localparam logic [7:0] OP_ACK_OFFSET   = 8'd100;
  localparam logic [7:0] CTRL_BOOT       = 8'd8;
  localparam logic [7:0] CTRL_RESET      = 8'd11;

  // command lengths
  localparam logic [7:0] LEN_MIN_CHECK = 8'd3;
  localparam logic [7:0] LEN_MIN_SB    = 8'd5;
  localparam logic [7:0] LEN_CTRL      = 8'd7;
  localparam logic [7:0] LEN_BAUD      = 8'd10;
  localparam logic [7:0] LEN_MAX       = 8'd255;
  localparam logic [15:0] TAIL_END     = {B_IAC, B_SE};

  // result kinds
  localparam logic [1:0] KIND_UART  = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_BAUD  = 2'd2;
  localparam logic [1:0] KIND_MODE  = 2'd3;

  // boot modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_BOOT   = 2'd1;
  localparam logic [1:0] MODE_RESET  = 2'd2;

  // source of the next result beat
  typedef enum logic [2:0] {
    SRC_RX        = 3'd0,
    SRC_BYTE      = 3'd1,
    SRC_REPLY     = 3'd2,
    SRC_BAUD      = 3'd3,
    SRC_MODE      = 3'd4,
    SRC_ECHO      = 3'd5,
    SRC_IDLE_BAUD = 3'd6,
    SRC_NORMAL    = 3'd7
  } out_src_t;

  typedef struct packed {
    logic     byte_load;
    logic     push_en;
    logic     push_iac;
    logic     clear_cmd;
    logic     esc_set;
    logic     esc_clr;
    logic     idx_clr;
    logic     idx_inc;
    logic     echo_load;
    logic     out_load;
    logic     out_last;
    out_src_t out_src;
  } ctrl_cmd_t;

  typedef struct packed {
    logic esc;
    logic len_zero;
    logic in_is_iac;
    logic out_free;
    logic chk_short;
    logic chk_do;
    logic do_echo_opt;
    logic chk_will;
    logic sb_frame;
    logic sb_ok;
    logic sb_baud;
    logic sb_mode;
    logic reply_last;
    logic echo_last;
  } dp_status_t;

  // reply to do echo: iac do com-port
  function automatic logic [7:0] reply_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      IDX_W'(0): b = B_IAC;
      IDX_W'(1): b = B_DO;
      default:   b = OPT_COMPORT;
    endcase
    return b;
  endfunction

endpackage

/* src/trxp_datapath.sv */
// ----------------------------------------------------------------------------
// trxp_datapath
// command buffer, escape flag, command checks and the output register
// ----------------------------------------------------------------------------
module trxp_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  trxp_pkg::ctrl_cmd_t   cmd,
  output trxp_pkg::dp_status_t  status,
  input  logic [7:0]            rx_byte,
  input  logic [31:0]           idle_baud,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [1:0]            kind,
  output logic [7:0]            data_byte,
  output logic [31:0]           baud_rate,
  output logic [1:0]            boot_mode,
  output logic                  last
);

  localparam int unsigned IW = trxp_pkg::IDX_W;

  logic            esc;
  logic [7:0]      len;
  logic [15:0]     tail;
  logic [7:0]      head [trxp_pkg::ECHO_DEPTH];
  logic [7:0]      byte_q;
  logic [IW-1:0]   idx;
  logic [IW-1:0]   echo_len;

  logic [7:0]      push_byte;
  logic [7:0]      op;
  logic [7:0]      echo_byte;
  logic [1:0]      kind_next;
  logic [7:0]      data_next;
  logic [31:0]     baud_next;
  logic [1:0]      mode_next;
  logic            plain_op;

  assign push_byte = cmd.push_iac ? trxp_pkg::B_IAC : byte_q;
  assign op        = head[3];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      esc       <= 1'b0;
      len       <= '0;
      tail      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.esc_set) begin
        esc <= 1'b1;
      end else if (cmd.esc_clr) begin
        esc <= 1'b0;
      end
      if (cmd.clear_cmd) begin
        len  <= '0;
        tail <= '0;
      end else if (cmd.push_en) begin
        tail <= {tail[7:0], push_byte};
        if (len != trxp_pkg::LEN_MAX) begin
          len <= len + 8'd1;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.byte_load) begin
      byte_q <= rx_byte;
    end
    if (cmd.push_en && (len < 8'(trxp_pkg::ECHO_DEPTH))) begin
      head[len[IW-1:0]] <= push_byte;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
    if (cmd.echo_load) begin
      echo_len <= len[IW-1:0];
    end
    if (cmd.out_load) begin
      kind      <= kind_next;
      data_byte <= data_next;
      baud_rate <= baud_next;
      boot_mode <= mode_next;
      last      <= cmd.out_last;
    end
  end

  // command checks on the buffered bytes
  assign plain_op = (op == trxp_pkg::OP_SET_DATASIZE) || (op == trxp_pkg::OP_SET_PARITY) ||
                    (op == trxp_pkg::OP_SET_STOPSIZE) || (op == trxp_pkg::OP_PURGE_DATA);

  always_comb begin
    status.esc         = esc;
    status.len_zero    = (len == 8'd0);
    status.in_is_iac   = (rx_byte == trxp_pkg::B_IAC);
    status.out_free    = !out_valid || out_ready;
    status.chk_short   = (len < trxp_pkg::LEN_MIN_CHECK);
    status.chk_do      = (head[1] == trxp_pkg::B_DO);
    status.do_echo_opt = (head[2] == trxp_pkg::OPT_ECHO);
    status.chk_will    = (head[1] == trxp_pkg::B_WILL);
    status.sb_frame    = (len >= trxp_pkg::LEN_MIN_SB) && (head[1] == trxp_pkg::B_SB) &&
                         (head[2] == trxp_pkg::OPT_COMPORT) && (tail == trxp_pkg::TAIL_END);
    status.sb_baud     = (op == trxp_pkg::OP_SET_BAUD) && (len == trxp_pkg::LEN_BAUD);
    status.sb_mode     = (op == trxp_pkg::OP_SET_CONTROL) && (len == trxp_pkg::LEN_CTRL) &&
                         ((head[4] == trxp_pkg::CTRL_BOOT) || (head[4] == trxp_pkg::CTRL_RESET));
    status.sb_ok       = status.sb_baud ||
                         ((len == trxp_pkg::LEN_CTRL) &&
                          (plain_op || (op == trxp_pkg::OP_SET_CONTROL)));
    status.reply_last  = (idx == IW'(2));
    status.echo_last   = (idx == (echo_len - IW'(1)));
  end

  // echo byte, opcode raised by the ack offset
  always_comb begin
    if (idx == IW'(3)) begin
      echo_byte = head[3] + trxp_pkg::OP_ACK_OFFSET;
    end else begin
      echo_byte = head[idx];
    end
  end

  // next result beat
  always_comb begin
    kind_next = trxp_pkg::KIND_UART;
    data_next = '0;
    baud_next = '0;
    mode_next = trxp_pkg::MODE_NORMAL;
    case (cmd.out_src)
      trxp_pkg::SRC_RX: begin
        data_next = rx_byte;
      end
      trxp_pkg::SRC_BYTE: begin
        data_next = byte_q;
      end
      trxp_pkg::SRC_REPLY: begin
        kind_next = trxp_pkg::KIND_REPLY;
        data_next = trxp_pkg::reply_byte(idx);
      end
      trxp_pkg::SRC_BAUD: begin
        kind_next = trxp_pkg::KIND_BAUD;
        baud_next = {head[4], head[5], head[6], head[7]};
      end
      trxp_pkg::SRC_MODE: begin
        kind_next = trxp_pkg::KIND_MODE;
        mode_next = (head[4] == trxp_pkg::CTRL_BOOT) ? trxp_pkg::MODE_BOOT
                                                      : trxp_pkg::MODE_RESET;
      end
      trxp_pkg::SRC_ECHO: begin
        kind_next = trxp_pkg::KIND_REPLY;
        data_next = echo_byte;
      end
      trxp_pkg::SRC_IDLE_BAUD: begin
        kind_next = trxp_pkg::KIND_BAUD;
        baud_next = idle_baud;
      end
      trxp_pkg::SRC_NORMAL: begin
        kind_next = trxp_pkg::KIND_MODE;
      end
      default: begin
        kind_next = trxp_pkg::KIND_UART;
      end
    endcase
  end

endmodule

/* src/trxp_ctrl.sv */
// ----------------------------------------------------------------------------
// trxp_ctrl
// sequencer: input acceptance, buffer pushes, command check and result beats
// ----------------------------------------------------------------------------
module trxp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  trxp_pkg::dp_status_t  status,
  output trxp_pkg::ctrl_cmd_t   cmd
);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b0000000001,
    S_DATA       = 10'b0000000010,
    S_PUSH       = 10'b0000000100,
    S_CHECK      = 10'b0000001000,
    S_REPLY      = 10'b0000010000,
    S_BAUD       = 10'b0000100000,
    S_MODE       = 10'b0001000000,
    S_ECHO       = 10'b0010000000,
    S_CLOSE_BAUD = 10'b0100000000,
    S_CLOSE_MODE = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   plain;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_src = trxp_pkg::SRC_RX;
    plain      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.byte_load = 1'b1;
          if (req_type) begin
            cmd.clear_cmd = 1'b1;
            cmd.esc_clr   = 1'b1;
            state_next    = S_CLOSE_BAUD;
          end else if (status.esc) begin
            cmd.esc_clr = 1'b1;
            if (!status.in_is_iac) begin
              // unpaired iac opens (or joins) a command
              cmd.push_en  = 1'b1;
              cmd.push_iac = 1'b1;
              state_next   = S_PUSH;
            end else begin
              plain = 1'b1;
            end
          end else if (status.in_is_iac) begin
            cmd.esc_set = 1'b1;
          end else begin
            plain = 1'b1;
          end
          if (plain) begin
            if (!status.len_zero) begin
              state_next = S_PUSH;
            end else if (status.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              cmd.out_src  = trxp_pkg::SRC_RX;
            end else begin
              state_next = S_DATA;
            end
          end
        end
      end
      S_DATA: begin
        cmd.out_src = trxp_pkg::SRC_BYTE;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_PUSH: begin
        cmd.push_en = 1'b1;
        state_next  = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_IDLE;
        if (status.chk_short) begin
          state_next = S_IDLE;
        end else if (status.chk_do) begin
          cmd.clear_cmd = 1'b1;
          if (status.do_echo_opt) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_REPLY;
          end
        end else if (status.chk_will) begin
          cmd.clear_cmd = 1'b1;
        end else if (status.sb_frame) begin
          cmd.clear_cmd = 1'b1;
          if (status.sb_ok) begin
            cmd.echo_load = 1'b1;
            cmd.idx_clr   = 1'b1;
            if (status.sb_baud) begin
              state_next = S_BAUD;
            end else if (status.sb_mode) begin
              state_next = S_MODE;
            end else begin
              state_next = S_ECHO;
            end
          end
        end
      end
      S_REPLY: begin
        cmd.out_src = trxp_pkg::SRC_REPLY;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = status.reply_last;
          cmd.idx_inc  = 1'b1;
          if (status.reply_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_BAUD: begin
        cmd.out_src = trxp_pkg::SRC_BAUD;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_ECHO;
        end
      end
      S_MODE: begin
        cmd.out_src = trxp_pkg::SRC_MODE;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_ECHO;
        end
      end
      S_ECHO: begin
        cmd.out_src = trxp_pkg::SRC_ECHO;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = status.echo_last;
          cmd.idx_inc  = 1'b1;
          if (status.echo_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_CLOSE_BAUD: begin
        cmd.out_src = trxp_pkg::SRC_IDLE_BAUD;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_CLOSE_MODE;
        end
      end
      S_CLOSE_MODE: begin
        cmd.out_src = trxp_pkg::SRC_NORMAL;
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/telnet_rfc2217_rx_parser_core.sv */
// ----------------------------------------------------------------------------
// telnet_rfc2217_rx_parser_core
// receive-side telnet parser with rfc 2217 com-port control
// ----------------------------------------------------------------------------
// Takes received socket bytes (req_type 0) or a connection-closed event
// (req_type 1), one beat at a time, and gives result beats: uart data bytes,
// socket reply bytes, set-baud and boot-mode commands; last marks the final
// beat caused by one input beat. A plain data byte, or a lone iac, is taken in
// idle, so a byte stream runs at one byte per clock while out_ready is high.
// A byte inside a pending telnet command goes through accept, buffer push
// and command check; results then leave one beat per cycle while out_ready
// is high, through the output register, up to eleven for a set-baud command.
// A close gives set-baud with idle_baud, then boot mode normal, and clears the
// parser. The sequencer in trxp_ctrl holds the input side off outside idle:
// while a command is pushed, checked or answered, or a beat waits on output.
// idle_baud sits at apb byte address 0 and may only be written while idle.
// ----------------------------------------------------------------------------
module telnet_rfc2217_rx_parser_core (
  input  logic                          clk,
  input  logic                          rst,

  // apb register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trxp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,

  // input beats
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [7:0]                    rx_byte,

  // result beats
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    kind,
  output logic [7:0]                    data_byte,
  output logic [31:0]                   baud_rate,
  output logic [1:0]                    boot_mode,
  output logic                          last
);

  logic                  idle_baud;
  logic [31:0]           idle_baud_reg;
  logic                  reg_sel;
  trxp_pkg::ctrl_cmd_t   cmd;
  trxp_pkg::dp_status_t  status;

  // register decode: word index sits above the byte offset
  assign reg_sel   = (paddr[trxp_pkg::ADDR_W-1] == trxp_pkg::REG_IDLE_BAUD);
  assign idle_baud = psel && penable && pwrite && reg_sel;
  assign pready    = 1'b1;
  assign prdata    = reg_sel ? idle_baud_reg : 32'd0;

  // idle baud register, keeps its value across a close
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_baud_reg <= trxp_pkg::IDLE_BAUD_RESET;
    end else if (idle_baud) begin
      idle_baud_reg <= pwdata;
    end
  end

  // sequencer
  trxp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd)
  );

  // command buffer and output register
  trxp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .rx_byte   (rx_byte),
    .idle_baud (idle_baud_reg),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .kind      (kind),
    .data_byte (data_byte),
    .baud_rate (baud_rate),
    .boot_mode (boot_mode),
    .last      (last)
  );

endmodule
